FILE: src/gamepad_deadzone_edge_qualifier_macros.svh
// ----------------------------------------------------------------------------
// gamepad deadzone edge qualifier assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_DEADZONE_EDGE_QUALIFIER_MACROS_SVH
`define GAMEPAD_DEADZONE_EDGE_QUALIFIER_MACROS_SVH
`ifndef SYNTHESIS
// check sampled on i_clk, off while i_rst_n is low
`define GDEQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gdeq check failed");
// check sampled on i_clk, also active during reset
`define GDEQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("gdeq check failed");
`else
`define GDEQ_ASSERT(lbl, prop)
`define GDEQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/gdeq_pkg.sv
// ----------------------------------------------------------------------------
// gdeq_pkg
// shared widths, codes, thresholds and the cordic arctangent table
// ----------------------------------------------------------------------------
package gdeq_pkg;

    // field widths
    localparam int AXIS_W    = 11;
    localparam int HAT_W     = 16;
    localparam int RAW_W     = 8;
    localparam int STAT_W    = 2;
    localparam int DZ_W      = 10;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_DZ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_DZ   = 1'b1;
    localparam logic [DZ_W-1:0]      COARSE_DZ_RST = 10'd300;
    localparam logic [DZ_W-1:0]      FINE_DZ_RST   = 10'd150;

    // read status codes, anything above hold means clear
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_HOLD = 2'd1;

    // press tracker
    typedef logic [1:0] t_trk;
    localparam t_trk TRK_NONE  = 2'd0;
    localparam t_trk TRK_PRESS = 2'd1;
    localparam t_trk TRK_HELD  = 2'd2;
    localparam t_trk TRK_REL   = 2'd3;

    typedef struct packed {
        logic upd;
        logic clr;
    } t_trk_cmd;

    // logical button positions
    localparam int BTN_LC_LEFT  = 0;
    localparam int BTN_LC_RIGHT = 1;
    localparam int BTN_LC_UP    = 2;
    localparam int BTN_LC_DOWN  = 3;
    localparam int BTN_RC_LEFT  = 4;
    localparam int BTN_RC_RIGHT = 5;
    localparam int BTN_RC_UP    = 6;
    localparam int BTN_RC_DOWN  = 7;
    localparam int BTN_LT       = 8;
    localparam int BTN_RT       = 9;
    localparam int BTN_LF_LEFT  = 10;
    localparam int BTN_LF_RIGHT = 11;
    localparam int BTN_LF_UP    = 12;
    localparam int BTN_LF_DOWN  = 13;
    localparam int BTN_FACE0    = 14;
    localparam int BTN_MENU     = 20;
    localparam int RAW_FACE_N   = 6;
    localparam int RAW_MENU     = 7;

    // hat sectors in hundredths of a degree
    localparam logic [HAT_W-1:0] HAT_FULL = 16'd36000;
    localparam logic [HAT_W-1:0] HAT_R_LO = 16'd58;
    localparam logic [HAT_W-1:0] HAT_R_HI = 16'd17942;
    localparam logic [HAT_W-1:0] HAT_L_LO = 16'd18058;
    localparam logic [HAT_W-1:0] HAT_L_HI = 16'd35942;
    localparam logic [HAT_W-1:0] HAT_U_HI = 16'd8942;
    localparam logic [HAT_W-1:0] HAT_U_LO = 16'd27058;
    localparam logic [HAT_W-1:0] HAT_D_LO = 16'd9058;
    localparam logic [HAT_W-1:0] HAT_D_HI = 16'd26942;

    // cordic datapath, angles in units of pi/2^31
    localparam int CORDIC_STEPS = 28;
    localparam int CNT_W        = 5;
    localparam int PRE_SHIFT    = 24;
    localparam int XY_W         = 40;
    localparam int Z_W          = 34;
    localparam int ATAN_W       = 30;

    // atan(2^-i)
    function automatic logic [ATAN_W-1:0] gdeq_atan(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/gamepad_deadzone_edge_qualifier.sv
// ----------------------------------------------------------------------------
// gamepad deadzone edge qualifier
// stick/trigger deadzones, hat sectors and face buttons into 21 logical
// buttons with press trackers, plus left and right stick angles by cordic
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   axes, hat, raw buttons, status
//   out      output     o_out_valid / i_out_stall masks, stick angles
//   cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// a good read runs one shared cordic unit through 28 micro-rotations per
// stick, left then right, and the input stalls until the result is registered
// a failed read (hold or clear) skips the cordic and goes straight to done
// i_rst_n is synchronous: trackers none, angles zero, deadzones 300 and 150
// the output register lets a new item in while the last result is stalled
// ----------------------------------------------------------------------------
`include "gamepad_deadzone_edge_qualifier_macros.svh"

module gamepad_deadzone_edge_qualifier import gdeq_pkg::*; #(
    parameter int NUM_LOGICAL_BUTTONS = 21,
    parameter int ANGLE_BITS          = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [AXIS_W-1:0]       i_left_x,
    input  logic signed [AXIS_W-1:0]       i_left_y,
    input  logic signed [AXIS_W-1:0]       i_trigger_z,
    input  logic signed [AXIS_W-1:0]       i_right_x,
    input  logic signed [AXIS_W-1:0]       i_right_y,
    input  logic [HAT_W-1:0]               i_hat_angle,
    input  logic                           i_hat_centered,
    input  logic [RAW_W-1:0]               i_raw_buttons,
    input  logic [STAT_W-1:0]              i_read_status,
    // result item
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [NUM_LOGICAL_BUTTONS-1:0] o_pressed_edge_mask,
    output logic [NUM_LOGICAL_BUTTONS-1:0] o_held_mask,
    output logic [NUM_LOGICAL_BUTTONS-1:0] o_released_edge_mask,
    output logic signed [ANGLE_BITS-1:0]   o_left_stick_angle,
    output logic signed [ANGLE_BITS-1:0]   o_right_stick_angle,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [DZ_W-1:0]                i_cfg_data
);

    localparam int NB = NUM_LOGICAL_BUTTONS;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_L_GO    = 3'd1;
    localparam logic [2:0] S_L_WAIT  = 3'd2;
    localparam logic [2:0] S_R_GO    = 3'd3;
    localparam logic [2:0] S_R_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [DZ_W-1:0]          r_coarse_dz, r_fine_dz;

    logic signed [AXIS_W-1:0] r_lx, r_ly, r_tz, r_rx, r_ry;
    logic [HAT_W-1:0]         r_hat;
    logic                     r_hat_ctr;
    logic [RAW_W-1:0]         r_raw;
    logic [STAT_W-1:0]        r_status;

    logic [ANGLE_BITS-1:0]    r_left_ang, r_right_ang;
    logic                     r_out_valid;
    logic [NB-1:0]            r_out_pm, r_out_hm, r_out_rm;
    logic [ANGLE_BITS-1:0]    r_out_la, r_out_ra;

    logic                     in_acc, out_free, finish;
    logic                     cor_start, cor_done;
    logic signed [AXIS_W:0]   cor_ay, cor_bx;
    logic [ANGLE_BITS-1:0]    cor_angle;
    logic [NB-1:0]            pressed, nx_pm, nx_hm, nx_rm;
    t_trk_cmd                 trk_cmd;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = (r_state == S_DONE) && out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_dz <= COARSE_DZ_RST;
            r_fine_dz   <= FINE_DZ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COARSE_DZ: r_coarse_dz <= i_cfg_data;
                CFG_FINE_DZ:   r_fine_dz   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lx      <= i_left_x;
            r_ly      <= i_left_y;
            r_tz      <= i_trigger_z;
            r_rx      <= i_right_x;
            r_ry      <= i_right_y;
            r_hat     <= i_hat_angle;
            r_hat_ctr <= i_hat_centered;
            r_raw     <= i_raw_buttons;
            r_status  <= i_read_status;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) begin
                n_state = (i_read_status == ST_OK) ? S_L_GO : S_DONE;
            end
            S_L_GO:   n_state = S_L_WAIT;
            S_L_WAIT: if (cor_done) begin
                n_state = S_R_GO;
            end
            S_R_GO:   n_state = S_R_WAIT;
            S_R_WAIT: if (cor_done) begin
                n_state = S_DONE;
            end
            S_DONE:   if (out_free) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // cordic operands: atan2(-x, -y) of the selected stick
    always_comb begin
        cor_start = (r_state == S_L_GO) || (r_state == S_R_GO);
        if (r_state == S_R_GO) begin
            cor_ay = -{r_rx[AXIS_W-1], r_rx};
            cor_bx = -{r_ry[AXIS_W-1], r_ry};
        end else begin
            cor_ay = -{r_lx[AXIS_W-1], r_lx};
            cor_bx = -{r_ly[AXIS_W-1], r_ly};
        end
    end

    gdeq_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_ay    (cor_ay),
        .i_bx    (cor_bx),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    // angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_ang  <= '0;
            r_right_ang <= '0;
        end else if (cor_done && r_state == S_L_WAIT) begin
            r_left_ang <= cor_angle;
        end else if (cor_done && r_state == S_R_WAIT) begin
            r_right_ang <= cor_angle;
        end
    end

    gdeq_classify #(
        .NUM_BTN (NB)
    ) u_classify (
        .i_left_x       (r_lx),
        .i_left_y       (r_ly),
        .i_trigger_z    (r_tz),
        .i_right_x      (r_rx),
        .i_right_y      (r_ry),
        .i_hat_angle    (r_hat),
        .i_hat_centered (r_hat_ctr),
        .i_raw_buttons  (r_raw),
        .i_coarse_dz    (r_coarse_dz),
        .i_fine_dz      (r_fine_dz),
        .o_pressed      (pressed)
    );

    // tracker command on completion
    always_comb begin
        trk_cmd.upd = finish && (r_status == ST_OK);
        trk_cmd.clr = finish && (r_status != ST_OK) && (r_status != ST_HOLD);
    end

    gdeq_tracker #(
        .NUM_BTN (NB)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (trk_cmd),
        .i_pressed       (pressed),
        .o_pressed_mask  (nx_pm),
        .o_held_mask     (nx_hm),
        .o_released_mask (nx_rm)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_pm <= nx_pm;
            r_out_hm <= nx_hm;
            r_out_rm <= nx_rm;
            r_out_la <= r_left_ang;
            r_out_ra <= r_right_ang;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_pressed_edge_mask  = r_out_pm;
    assign o_held_mask          = r_out_hm;
    assign o_released_edge_mask = r_out_rm;
    assign o_left_stick_angle   = r_out_la;
    assign o_right_stick_angle  = r_out_ra;

    // checks
    `GDEQ_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> r_state == S_IDLE && !o_out_valid)
    `GDEQ_ASSERT(a_out_from_done, $rose(o_out_valid) |-> $past(r_state) == S_DONE)
    `GDEQ_ASSERT(a_cor_done_wait, cor_done |-> r_state == S_L_WAIT || r_state == S_R_WAIT)
    `GDEQ_ASSERT(a_masks_excl, o_out_valid |->
        ((o_pressed_edge_mask & o_held_mask) == '0) &&
        ((o_held_mask & o_released_edge_mask) == '0) &&
        ((o_pressed_edge_mask & o_released_edge_mask) == '0))

endmodule

FILE: src/gdeq_classify.sv
// ----------------------------------------------------------------------------
// gdeq_classify
// deadzone, trigger, hat sector and face button decode into pressed levels
// ----------------------------------------------------------------------------
module gdeq_classify import gdeq_pkg::*; #(
    parameter int NUM_BTN = 21
) (
    input  logic signed [AXIS_W-1:0] i_left_x,
    input  logic signed [AXIS_W-1:0] i_left_y,
    input  logic signed [AXIS_W-1:0] i_trigger_z,
    input  logic signed [AXIS_W-1:0] i_right_x,
    input  logic signed [AXIS_W-1:0] i_right_y,
    input  logic [HAT_W-1:0]         i_hat_angle,
    input  logic                     i_hat_centered,
    input  logic [RAW_W-1:0]         i_raw_buttons,
    input  logic [DZ_W-1:0]          i_coarse_dz,
    input  logic [DZ_W-1:0]          i_fine_dz,
    output logic [NUM_BTN-1:0]       o_pressed
);

    // {pos, neg}; the negative side wins
    function automatic logic [1:0] dir(input logic signed [AXIS_W-1:0] v,
                                       input logic [DZ_W-1:0] dz);
        logic signed [AXIS_W:0] ve;
        logic signed [AXIS_W:0] lim;
        logic                   neg;
        logic                   pos;
        ve  = {v[AXIS_W-1], v};
        lim = {{(AXIS_W+1-DZ_W){1'b0}}, dz};
        neg = (ve < -lim);
        pos = !neg && (ve > lim);
        return {pos, neg};
    endfunction

    logic [1:0]       d_lcx, d_lcy, d_rcx, d_rcy, d_tz, d_lfx, d_lfy;
    logic [HAT_W:0]   hat_sub;
    logic [HAT_W-1:0] hat_mod;

    // fold hat angle into one turn
    assign hat_sub = {1'b0, i_hat_angle} - {1'b0, HAT_FULL};
    assign hat_mod = hat_sub[HAT_W] ? i_hat_angle : hat_sub[HAT_W-1:0];

    // axis thresholds
    assign d_lcx = dir(i_left_x, i_coarse_dz);
    assign d_lcy = dir(i_left_y, i_coarse_dz);
    assign d_rcx = dir(i_right_x, i_coarse_dz);
    assign d_rcy = dir(i_right_y, i_coarse_dz);
    assign d_tz  = dir(i_trigger_z, i_coarse_dz);
    assign d_lfx = dir(i_left_x, i_fine_dz);
    assign d_lfy = dir(i_left_y, i_fine_dz);

    // pressed levels
    always_comb begin
        o_pressed = '0;
        o_pressed[BTN_LC_LEFT]  = d_lcx[0];
        o_pressed[BTN_LC_RIGHT] = d_lcx[1];
        o_pressed[BTN_LC_UP]    = d_lcy[0];
        o_pressed[BTN_LC_DOWN]  = d_lcy[1];
        o_pressed[BTN_RC_LEFT]  = d_rcx[0];
        o_pressed[BTN_RC_RIGHT] = d_rcx[1];
        o_pressed[BTN_RC_UP]    = d_rcy[0];
        o_pressed[BTN_RC_DOWN]  = d_rcy[1];
        o_pressed[BTN_LT]       = d_tz[1];
        o_pressed[BTN_RT]       = d_tz[0];
        o_pressed[BTN_LF_LEFT]  = d_lfx[0];
        o_pressed[BTN_LF_RIGHT] = d_lfx[1];
        o_pressed[BTN_LF_UP]    = d_lfy[0];
        o_pressed[BTN_LF_DOWN]  = d_lfy[1];
        for (int k = 0; k < RAW_FACE_N; k++) begin
            o_pressed[BTN_FACE0 + k] = i_raw_buttons[k];
        end
        o_pressed[BTN_MENU] = i_raw_buttons[RAW_MENU];

        // hat ors into the coarse left stick directions
        if (!i_hat_centered) begin
            if (hat_mod >= HAT_R_LO && hat_mod <= HAT_R_HI) begin
                o_pressed[BTN_LC_RIGHT] = 1'b1;
            end else if (hat_mod >= HAT_L_LO && hat_mod <= HAT_L_HI) begin
                o_pressed[BTN_LC_LEFT] = 1'b1;
            end
            if (hat_mod <= HAT_U_HI || hat_mod >= HAT_U_LO) begin
                o_pressed[BTN_LC_UP] = 1'b1;
            end else if (hat_mod >= HAT_D_LO && hat_mod <= HAT_D_HI) begin
                o_pressed[BTN_LC_DOWN] = 1'b1;
            end
        end
    end

endmodule

FILE: src/gdeq_tracker.sv
// ----------------------------------------------------------------------------
// gdeq_tracker
// four-state press tracker per logical button, masks of the next state
// ----------------------------------------------------------------------------
module gdeq_tracker import gdeq_pkg::*; #(
    parameter int NUM_BTN = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_trk_cmd           i_cmd,
    input  logic [NUM_BTN-1:0] i_pressed,
    output logic [NUM_BTN-1:0] o_pressed_mask,
    output logic [NUM_BTN-1:0] o_held_mask,
    output logic [NUM_BTN-1:0] o_released_mask
);

    t_trk r_trk [NUM_BTN];
    t_trk n_trk [NUM_BTN];

    // next tracker state and its masks
    always_comb begin
        for (int b = 0; b < NUM_BTN; b++) begin
            n_trk[b] = r_trk[b];
            if (i_cmd.clr) begin
                n_trk[b] = TRK_NONE;
            end else if (i_cmd.upd) begin
                if (i_pressed[b]) begin
                    n_trk[b] = (r_trk[b] == TRK_NONE) ? TRK_PRESS : TRK_HELD;
                end else begin
                    n_trk[b] = (r_trk[b] == TRK_HELD) ? TRK_REL : TRK_NONE;
                end
            end
            o_pressed_mask[b]  = (n_trk[b] == TRK_PRESS);
            o_held_mask[b]     = (n_trk[b] == TRK_HELD);
            o_released_mask[b] = (n_trk[b] == TRK_REL);
        end
    end

    // tracker registers
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BTN; b++) begin
            if (!i_rst_n) begin
                r_trk[b] <= TRK_NONE;
            end else begin
                r_trk[b] <= n_trk[b];
            end
        end
    end

endmodule

FILE: src/gdeq_cordic.sv
// ----------------------------------------------------------------------------
// gdeq_cordic
// iterative vectoring cordic, one micro-rotation per cycle, atan2(ay, bx)
// ----------------------------------------------------------------------------
module gdeq_cordic import gdeq_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [AXIS_W:0]  i_ay,
    input  logic signed [AXIS_W:0]  i_bx,
    output logic                    o_done,
    output logic [ANGLE_BITS-1:0]   o_angle
);

    localparam int RND_SH = 32 - ANGLE_BITS;
    localparam int PAD_W  = XY_W - (AXIS_W + 1) - PRE_SHIFT;
    localparam logic signed [Z_W-1:0] Z_QTR = {{(Z_W-31){1'b0}}, 1'b1, 30'd0};
    localparam logic signed [Z_W-1:0] Z_RND = {{(Z_W-RND_SH){1'b0}}, 1'b1,
                                               {(RND_SH-1){1'b0}}};
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CORDIC_STEPS);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_zero;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [ANGLE_BITS-1:0]  r_angle;

    logic signed [XY_W-1:0] x0, y0, x_pre, y_pre, xs, ys;
    logic signed [Z_W-1:0]  z_pre, at, z_rnd;

    // scale inputs and pre-rotate into the right half plane
    always_comb begin
        x0    = {{PAD_W{i_bx[AXIS_W]}}, i_bx, {PRE_SHIFT{1'b0}}};
        y0    = {{PAD_W{i_ay[AXIS_W]}}, i_ay, {PRE_SHIFT{1'b0}}};
        x_pre = x0;
        y_pre = y0;
        z_pre = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                x_pre = y0;
                y_pre = -x0;
                z_pre = Z_QTR;
            end else begin
                x_pre = -y0;
                y_pre = x0;
                z_pre = -Z_QTR;
            end
        end
    end

    // shared shift-add step
    assign xs    = r_x >>> r_cnt;
    assign ys    = r_y >>> r_cnt;
    assign at    = {{(Z_W-ATAN_W){1'b0}}, gdeq_atan(r_cnt)};
    assign z_rnd = r_z + Z_RND;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x    <= x_pre;
            r_y    <= y_pre;
            r_z    <= z_pre;
            r_zero <= (i_ay == '0) && (i_bx == '0);
        end else if (r_busy && r_cnt != LAST_CNT) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end else if (r_busy) begin
            r_angle <= r_zero ? '0 : z_rnd[RND_SH +: ANGLE_BITS];
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

FILE: tb/sv/tb_gamepad_deadzone_edge_qualifier.sv
// ----------------------------------------------------------------------------
// tb_gamepad_deadzone_edge_qualifier
// self-checking bench for the gamepad deadzone edge qualifier: an in-bench
// predictor tracks the 21 press trackers, both deadzones and the cordic stick
// angles; directed polls cover thresholds, hat sectors and read status, then
// random poll sequences run under bursty input and patterned output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gamepad_deadzone_edge_qualifier import gdeq_pkg::*;;

    localparam int NUM_BTN        = 21;
    localparam int ANGLE_W        = 16;
    localparam int CORDIC_N       = 28;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_SETTLE     = 70;
    localparam int RAND_PHASES    = 5;
    localparam int PHASE_POLLS    = 380;

    // read status codes above hold, both clear the trackers
    localparam logic [STAT_W-1:0] ST_CLEAR     = 2'd2;
    localparam logic [STAT_W-1:0] ST_CLEAR_ALT = 2'd3;

    // logical button positions
    localparam int B_LC_LEFT = 0;
    localparam int B_LC_RIGHT = 1;
    localparam int B_LC_UP = 2;
    localparam int B_LC_DOWN = 3;
    localparam int B_RC_LEFT = 4;
    localparam int B_RC_UP = 6;
    localparam int B_LT = 8;
    localparam int B_RT = 9;
    localparam int B_LF_LEFT = 10;
    localparam int B_LF_UP = 12;
    localparam int B_FACE = 14;
    localparam int B_MENU = 20;

    // hat sector limits, hundredths of a degree
    localparam int HAT_TURN = 36000;
    localparam int HR_LO = 58;
    localparam int HR_HI = 17942;
    localparam int HL_LO = 18058;
    localparam int HL_HI = 35942;
    localparam int HU_HI = 8942;
    localparam int HU_LO = 27058;
    localparam int HD_LO = 9058;
    localparam int HD_HI = 26942;

    typedef enum logic [1:0] {PT_IDLE, PT_PRESSED, PT_HELD, PT_RELEASED} t_press_state;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct {
        logic signed [AXIS_W-1:0] left_x;
        logic signed [AXIS_W-1:0] left_y;
        logic signed [AXIS_W-1:0] trigger_z;
        logic signed [AXIS_W-1:0] right_x;
        logic signed [AXIS_W-1:0] right_y;
        logic [HAT_W-1:0]         hat_angle;
        logic                     hat_centered;
        logic [RAW_W-1:0]         raw_buttons;
        logic [STAT_W-1:0]        read_status;
    } t_pad_poll;

    typedef struct {
        logic [NUM_BTN-1:0] pressed;
        logic [NUM_BTN-1:0] held;
        logic [NUM_BTN-1:0] released;
        logic [ANGLE_W-1:0] left_ang;
        logic [ANGLE_W-1:0] right_ang;
    } t_pad_report;

    // atan(2^-i) in units of pi/2^31
    longint atan_lut [CORDIC_N] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [AXIS_W-1:0] left_x = '0;
    logic signed [AXIS_W-1:0] left_y = '0;
    logic signed [AXIS_W-1:0] trigger_z = '0;
    logic signed [AXIS_W-1:0] right_x = '0;
    logic signed [AXIS_W-1:0] right_y = '0;
    logic [HAT_W-1:0]         hat_angle = '0;
    logic                     hat_centered = 1'b1;
    logic [RAW_W-1:0]         raw_buttons = '0;
    logic [STAT_W-1:0]        read_status = ST_OK;

    logic                       o_out_valid;
    logic                       out_stall = 1'b0;
    logic [NUM_BTN-1:0]         o_pressed_edge_mask;
    logic [NUM_BTN-1:0]         o_held_mask;
    logic [NUM_BTN-1:0]         o_released_edge_mask;
    logic signed [ANGLE_W-1:0]  o_left_stick_angle;
    logic signed [ANGLE_W-1:0]  o_right_stick_angle;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_COARSE_DZ;
    logic [DZ_W-1:0]      cfg_data = '0;

    // predictor state
    t_press_state       trk_state [NUM_BTN];
    logic [ANGLE_W-1:0] left_ang_q;
    logic [ANGLE_W-1:0] right_ang_q;
    int                 coarse_dz;
    int                 fine_dz;

    t_pad_report report_q [$];
    t_pad_poll   last_poll;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          hold_count = 0;
    bit          pace_on = 1'b0;
    int          burst_left = 0;

    gamepad_deadzone_edge_qualifier #(
        .NUM_LOGICAL_BUTTONS(NUM_BTN),
        .ANGLE_BITS(ANGLE_W)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_left_x(left_x),
        .i_left_y(left_y),
        .i_trigger_z(trigger_z),
        .i_right_x(right_x),
        .i_right_y(right_y),
        .i_hat_angle(hat_angle),
        .i_hat_centered(hat_centered),
        .i_raw_buttons(raw_buttons),
        .i_read_status(read_status),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_pressed_edge_mask(o_pressed_edge_mask),
        .o_held_mask(o_held_mask),
        .o_released_edge_mask(o_released_edge_mask),
        .o_left_stick_angle(o_left_stick_angle),
        .o_right_stick_angle(o_right_stick_angle),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // atan2(ay, bx) by vectoring cordic, rounded to the angle width
    function automatic logic [ANGLE_W-1:0] stick_angle(input longint ay, input longint bx);
        longint x, y, z, t, xs, ys;
        if (ay == 0 && bx == 0) begin
            return '0;
        end
        x = bx * 64'sd16777216;
        y = ay * 64'sd16777216;
        z = 0;
        // left half plane: pre-rotate by a quarter turn
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 64'sd1073741824;
            end else begin
                x = -y;
                y = t;
                z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[i];
            end
        end
        z = (z + 64'sd32768) >>> 16;
        return z[ANGLE_W-1:0];
    endfunction

    // {positive, negative} direction levels, negative wins
    function automatic logic [1:0] axis_dir(input int v, input int dz);
        logic neg;
        neg = v < -dz;
        return {!neg && (v > dz), neg};
    endfunction

    // advance the trackers for one poll and form its report
    function automatic t_pad_report predict_report(input t_pad_poll p);
        logic [NUM_BTN-1:0] lvl;
        logic [1:0]         trig;
        int                 h;
        t_pad_report        r;
        lvl = '0;
        if (p.read_status == ST_OK) begin
            lvl[B_LC_LEFT +: 2] = axis_dir(p.left_x, coarse_dz);
            lvl[B_LC_UP +: 2]   = axis_dir(p.left_y, coarse_dz);
            lvl[B_RC_LEFT +: 2] = axis_dir(p.right_x, coarse_dz);
            lvl[B_RC_UP +: 2]   = axis_dir(p.right_y, coarse_dz);
            lvl[B_LF_LEFT +: 2] = axis_dir(p.left_x, fine_dz);
            lvl[B_LF_UP +: 2]   = axis_dir(p.left_y, fine_dz);
            // trigger: positive is lt, negative is rt
            trig = axis_dir(p.trigger_z, coarse_dz);
            lvl[B_LT] = trig[1];
            lvl[B_RT] = trig[0];
            left_ang_q  = stick_angle(-longint'(p.left_x), -longint'(p.left_y));
            right_ang_q = stick_angle(-longint'(p.right_x), -longint'(p.right_y));
            // hat sectors fold into the coarse left stick directions
            if (!p.hat_centered) begin
                h = int'(p.hat_angle) % HAT_TURN;
                if (h >= HR_LO && h <= HR_HI) begin
                    lvl[B_LC_RIGHT] = 1'b1;
                end else if (h >= HL_LO && h <= HL_HI) begin
                    lvl[B_LC_LEFT] = 1'b1;
                end
                if (h <= HU_HI || h >= HU_LO) begin
                    lvl[B_LC_UP] = 1'b1;
                end else if (h >= HD_LO && h <= HD_HI) begin
                    lvl[B_LC_DOWN] = 1'b1;
                end
            end
            // face buttons, raw bit six unused
            lvl[B_FACE +: 6] = p.raw_buttons[5:0];
            lvl[B_MENU]      = p.raw_buttons[7];
            for (int i = 0; i < NUM_BTN; i++) begin
                if (lvl[i]) begin
                    trk_state[i] = (trk_state[i] == PT_IDLE) ? PT_PRESSED : PT_HELD;
                end else begin
                    trk_state[i] = (trk_state[i] == PT_HELD) ? PT_RELEASED : PT_IDLE;
                end
            end
        end else if (p.read_status != ST_HOLD) begin
            for (int i = 0; i < NUM_BTN; i++) begin
                trk_state[i] = PT_IDLE;
            end
        end
        r.pressed  = '0;
        r.held     = '0;
        r.released = '0;
        for (int i = 0; i < NUM_BTN; i++) begin
            case (trk_state[i])
                PT_PRESSED:  r.pressed[i] = 1'b1;
                PT_HELD:     r.held[i] = 1'b1;
                PT_RELEASED: r.released[i] = 1'b1;
                default: ;
            endcase
        end
        r.left_ang  = left_ang_q;
        r.right_ang = right_ang_q;
        return r;
    endfunction

    function automatic t_pad_poll make_poll(input int lx, input int ly, input int tz,
                                            input int rx, input int ry, input int hat,
                                            input bit cent, input int raw,
                                            input logic [STAT_W-1:0] st);
        t_pad_poll p;
        p.left_x       = AXIS_W'(lx);
        p.left_y       = AXIS_W'(ly);
        p.trigger_z    = AXIS_W'(tz);
        p.right_x      = AXIS_W'(rx);
        p.right_y      = AXIS_W'(ry);
        p.hat_angle    = HAT_W'(hat);
        p.hat_centered = cent;
        p.raw_buttons  = RAW_W'(raw);
        p.read_status  = st;
        return p;
    endfunction

    // axis value: near a deadzone edge, full field range, extremes or uniform
    function automatic logic signed [AXIS_W-1:0] rand_axis();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = $urandom_range(0, 1) ? coarse_dz : fine_dz;
                v = v + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
                if (v > 1023) v = 1023;
                if (v < -1024) v = -1024;
            end
            4, 5: v = int'($signed(11'($urandom())));
            6: begin
                case ($urandom_range(0, 4))
                    0: v = -1024;
                    1: v = -1000;
                    2: v = 0;
                    3: v = 1000;
                    default: v = 1023;
                endcase
            end
            default: v = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return AXIS_W'(v);
    endfunction

    function automatic logic [HAT_W-1:0] rand_hat();
        int edges [10] = '{HR_LO, HR_HI, HL_LO, HL_HI, HU_HI, HU_LO, HD_LO, HD_HI, 0, HAT_TURN};
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, HAT_TURN - 1);
            6, 7: v = $urandom_range(0, 65535);
            default: v = edges[$urandom_range(0, 9)] + int'($urandom_range(0, 2)) - 1;
        endcase
        return v[HAT_W-1:0];
    endfunction

    function automatic logic [STAT_W-1:0] rand_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84) return ST_OK;
        if (r < 92) return ST_HOLD;
        if (r < 97) return ST_CLEAR;
        return ST_CLEAR_ALT;
    endfunction

    // mostly small changes to the previous poll so trackers reach held
    function automatic t_pad_poll random_poll(input t_pad_poll prev);
        t_pad_poll p;
        int        bi;
        if ($urandom_range(0, 99) < 55) begin
            p = prev;
            case ($urandom_range(0, 4))
                0: begin
                    bi = $urandom_range(0, 7);
                    p.raw_buttons[bi] = ~p.raw_buttons[bi];
                end
                1: p.left_x = rand_axis();
                2: p.hat_angle = rand_hat();
                3: p.trigger_z = rand_axis();
                default: ;
            endcase
        end else begin
            p.left_x       = rand_axis();
            p.left_y       = rand_axis();
            p.trigger_z    = rand_axis();
            p.right_x      = rand_axis();
            p.right_y      = rand_axis();
            p.hat_angle    = rand_hat();
            p.hat_centered = ($urandom_range(0, 3) == 0);
            p.raw_buttons  = RAW_W'($urandom_range(0, 255));
        end
        p.read_status = rand_status();
        return p;
    endfunction

    // offer one poll and hold it until accepted; valid stays high
    task automatic send_poll(input t_pad_poll p);
        if (!in_valid) begin
            in_valid <= 1'b1;
        end
        left_x       <= p.left_x;
        left_y       <= p.left_y;
        trigger_z    <= p.trigger_z;
        right_x      <= p.right_x;
        right_y      <= p.right_y;
        hat_angle    <= p.hat_angle;
        hat_centered <= p.hat_centered;
        raw_buttons  <= p.raw_buttons;
        read_status  <= p.read_status;
        @(posedge clk);
        while (o_in_stall) begin
            @(posedge clk);
        end
        report_q.push_back(predict_report(p));
        last_poll = p;
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // bursts of random length with random gaps when pacing is on
    task automatic send_paced(input t_pad_poll p);
        if (pace_on) begin
            if (burst_left == 0) begin
                idle_for($urandom_range(0, 12));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        send_poll(p);
    endtask

    // stop offering and wait for every expected report
    task automatic drain();
        if (in_valid) begin
            in_valid <= 1'b0;
        end
        @(posedge clk);
        while (report_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_deadzone(input logic [CFG_IDX_W-1:0] idx, input int val);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[DZ_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_COARSE_DZ) begin
            coarse_dz = val;
        end else begin
            fine_dz = val;
        end
    endtask

    // deadzone edges at reset values, stick angle zero and pi
    task automatic test_thresholds_and_angles();
        send_poll(make_poll(0, 0, 0, 0, 0, 0, 1'b1, 8'h00, ST_OK));
        send_poll(make_poll(0, 1000, 1000, 0, -1000, 0, 1'b0, 8'hFF, ST_OK));
        send_poll(make_poll(0, 1000, 1000, 0, -1000, 0, 1'b0, 8'hFF, ST_OK));
        send_poll(make_poll(301, -301, -301, -1024, 1023, 9058, 1'b1, 8'h40, ST_OK));
        send_poll(make_poll(300, 151, 300, 1000, -1, 0, 1'b1, 8'h00, ST_OK));
        send_poll(make_poll(-150, -151, -300, -1000, 1000, 0, 1'b1, 8'h00, ST_OK));
    endtask

    // sector boundaries, wrap above a full turn, centered hat
    task automatic test_hat_sectors();
        int hats [11] = '{57, 58, 8942, 8943, 17943, 18058, 26942, 27058, 35942,
                          35999, 65535};
        foreach (hats[i]) begin
            send_poll(make_poll(0, 0, 0, 0, 0, hats[i], 1'b0, 8'h00, ST_OK));
        end
        send_poll(make_poll(0, 0, 0, 0, 0, 9000, 1'b1, 8'h00, ST_OK));
    endtask

    // failed reads: hold keeps trackers, clear empties them
    task automatic test_read_status();
        t_pad_poll press, rest;
        press = make_poll(-1000, -1000, 1000, 1000, 1000, 18058, 1'b0, 8'hBF, ST_OK);
        rest  = make_poll(0, 0, 0, 0, 0, 0, 1'b1, 8'h00, ST_OK);
        send_poll(press);
        send_poll(make_poll(0, 0, 0, 0, 0, 0, 1'b1, 8'h00, ST_HOLD));
        send_poll(press);
        send_poll(make_poll(0, 0, 0, 0, 0, 0, 1'b1, 8'h00, ST_CLEAR));
        send_poll(press);
        send_poll(make_poll(0, 0, 0, 0, 0, 0, 1'b1, 8'h00, ST_CLEAR_ALT));
        send_poll(rest);
    endtask

    // deadzones at their extremes
    task automatic test_deadzone_extremes();
        write_deadzone(CFG_COARSE_DZ, 0);
        write_deadzone(CFG_FINE_DZ, 1000);
        send_poll(make_poll(1, -1, 1, -1, 1, 0, 1'b1, 8'h00, ST_OK));
        send_poll(make_poll(1000, -1000, -1, 0, 0, 0, 1'b1, 8'h00, ST_OK));
        write_deadzone(CFG_COARSE_DZ, 1000);
        write_deadzone(CFG_FINE_DZ, 0);
        send_poll(make_poll(1000, -1000, 1000, -1001, 1001, 0, 1'b1, 8'h00, ST_OK));
        send_poll(make_poll(-1, 1, -1000, -1024, 1023, 0, 1'b1, 8'h00, ST_OK));
    endtask

    // long receiver hold-off while polls keep coming, input must stall
    task automatic test_backpressure();
        drain();
        pace_on = 1'b0;
        hold_count++;
        repeat (12) send_poll(random_poll(last_poll));
        drain();
    endtask

    task automatic test_random_polls();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_deadzone(CFG_COARSE_DZ, 1000);
                    write_deadzone(CFG_FINE_DZ, 0);
                end
                1: begin
                    write_deadzone(CFG_COARSE_DZ, 0);
                    write_deadzone(CFG_FINE_DZ, 1000);
                end
                default: begin
                    write_deadzone(CFG_COARSE_DZ, $urandom_range(0, 1000));
                    write_deadzone(CFG_FINE_DZ, $urandom_range(0, 1000));
                end
            endcase
            pace_on = (ph != 2);
            burst_left = 0;
            repeat (PHASE_POLLS) send_paced(random_poll(last_poll));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare each accepted report with the oldest prediction
    always @(posedge clk) begin : report_check
        t_pad_report want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (report_q.size() == 0) begin
                $display("%0t ns: unexpected report, expected none got pressed 0x%0h",
                         $time, o_pressed_edge_mask);
                fail_count++;
            end else begin
                want = report_q.pop_front();
                check_field("pressed_edge_mask", 32'(want.pressed),
                            32'(o_pressed_edge_mask));
                check_field("held_mask", 32'(want.held), 32'(o_held_mask));
                check_field("released_edge_mask", 32'(want.released),
                            32'(o_released_edge_mask));
                check_field("left_stick_angle", 32'(want.left_ang),
                            32'($unsigned(o_left_stick_angle)));
                check_field("right_stick_angle", 32'(want.right_ang),
                            32'($unsigned(o_right_stick_angle)));
            end
        end
    end

    // receiver stall pattern, plus the long hold-off on request
    always @(posedge clk) begin : rx_stall
        static int       hold_left = 0;
        static int       hold_done = 0;
        static int       mode_left = 0;
        static int       tick = 0;
        static t_rx_mode mode = RX_OPEN;
        tick++;
        if (hold_done != hold_count) begin
            hold_done = hold_count;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (mode)
                RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: out_stall <= (tick % 4 == 0);
                default:     out_stall <= 1'b0;
            endcase
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (trk_state[i]) begin
            trk_state[i] = PT_IDLE;
        end
        left_ang_q  = '0;
        right_ang_q = '0;
        coarse_dz   = int'(COARSE_DZ_RST);
        fine_dz     = int'(FINE_DZ_RST);
        last_poll   = make_poll(0, 0, 0, 0, 0, 0, 1'b1, 8'h00, ST_OK);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_thresholds_and_angles();
        test_hat_sectors();
        test_read_status();
        test_deadzone_extremes();
        test_backpressure();
        test_random_polls();

        drain();
        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/gdeq_pkg.sv
src/gdeq_classify.sv
src/gdeq_tracker.sv
src/gdeq_cordic.sv
src/gamepad_deadzone_edge_qualifier.sv
tb/sv/tb_gamepad_deadzone_edge_qualifier.sv
